// ===== rtl/gcrb_pkg.sv =====
// Shared types, constants and functions for the great-circle range and bearing block.
// Holds the CORDIC data word, the root cell word, the arctangent table and fixed-point helpers.
// No dependencies.
package gcrb_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int SQRT_STEPS   = 32;
    localparam int STEP_W       = 5;

    localparam int CORDIC_W = 36;   // x and y of a CORDIC cell
    localparam int ZW       = 34;   // angle accumulator, turns Q32
    localparam int SW       = 32;   // sine and cosine, Q30
    localparam int MW       = 34;   // Q30 products
    localparam int ROOT_W   = 63;   // radicand and partial root

    // Fixed-point pipeline depth from input register to output stage
    localparam int PIPE_LAT  = 2 * CORDIC_STEPS + SQRT_STEPS + 13;
    localparam int DEG_DELAY = SQRT_STEPS + 2;

    localparam logic signed [MW-1:0]       ONE_Q30   = MW'(64'sd1073741824);
    localparam logic signed [CORDIC_W-1:0] CORDIC_K  = CORDIC_W'(64'sd652032874);
    localparam logic [26:0]                DIV45_M   = 27'd95443718;
    localparam logic [26:0]                LAT_BIAS  = 27'd23592960;
    localparam logic [24:0]                FULL_DEG  = 25'd23592960;

    // Twice two pi in Q30, split so each partial product stays narrow
    localparam logic [63:0] RC_FULL  = 64'd13493037704;
    localparam int          RC_SPLIT = 17;
    localparam logic [16:0] RC_HI    = 17'(RC_FULL >> RC_SPLIT);
    localparam logic [16:0] RC_LO    = 17'(RC_FULL % (64'd1 << RC_SPLIT));

    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [ZW-1:0]       z;
    } cordic_t;

    typedef struct packed {
        logic [ROOT_W-1:0] n;
        logic [ROOT_W-1:0] root;
    } sqrt_t;

    // atan(2^-i) in turns, Q32, rounded
    function automatic logic [31:0] atan_entry(input logic [STEP_W-1:0] idx);
        logic [31:0] val;
        unique case (idx)
            5'd0:  val = 32'd536870912;
            5'd1:  val = 32'd316933406;
            5'd2:  val = 32'd167458907;
            5'd3:  val = 32'd85004756;
            5'd4:  val = 32'd42667331;
            5'd5:  val = 32'd21354465;
            5'd6:  val = 32'd10679838;
            5'd7:  val = 32'd5340245;
            5'd8:  val = 32'd2670163;
            5'd9:  val = 32'd1335087;
            5'd10: val = 32'd667544;
            5'd11: val = 32'd333772;
            5'd12: val = 32'd166886;
            5'd13: val = 32'd83443;
            5'd14: val = 32'd41722;
            5'd15: val = 32'd20861;
            5'd16: val = 32'd10430;
            5'd17: val = 32'd5215;
            5'd18: val = 32'd2608;
            5'd19: val = 32'd1304;
            5'd20: val = 32'd652;
            5'd21: val = 32'd326;
            5'd22: val = 32'd163;
            5'd23: val = 32'd81;
            5'd24: val = 32'd41;
            5'd25: val = 32'd20;
            5'd26: val = 32'd10;
            5'd27: val = 32'd5;
            5'd28: val = 32'd3;
            5'd29: val = 32'd1;
            5'd30: val = 32'd1;
            5'd31: val = 32'd0;
        endcase
        return val;
    endfunction

    // Q30 times Q30, floored back to Q30
    function automatic logic signed [MW-1:0] mulq(input logic signed [MW-1:0] a,
                                                 input logic signed [MW-1:0] b);
        logic signed [2*MW-1:0] p;
        p = a * b;
        return p[MW+29:30];
    endfunction

endpackage

// ===== rtl/gcrb_rot_cell.sv =====
// One rotation-mode CORDIC iteration with its output register.
// Depends on gcrb_pkg for the data word and the arctangent table.
module gcrb_rot_cell (
    input  logic                          clk,
    input  logic                          en,
    input  logic [gcrb_pkg::STEP_W-1:0]   step,
    input  gcrb_pkg::cordic_t             d_in,
    output gcrb_pkg::cordic_t             d_out
);

    gcrb_pkg::cordic_t d_next;
    gcrb_pkg::cordic_t d_reg;
    logic signed [gcrb_pkg::CORDIC_W-1:0] xv;
    logic signed [gcrb_pkg::CORDIC_W-1:0] yv;
    logic signed [gcrb_pkg::CORDIC_W-1:0] xs;
    logic signed [gcrb_pkg::CORDIC_W-1:0] ys;
    logic signed [gcrb_pkg::ZW-1:0]       zv;
    logic signed [gcrb_pkg::ZW-1:0]       at;

    always_comb
    begin
        xv = d_in.x;
        yv = d_in.y;
        zv = d_in.z;
        xs = xv >>> step;
        ys = yv >>> step;
        at = signed'(gcrb_pkg::ZW'(gcrb_pkg::atan_entry(step)));
        // rotate toward zero residual angle
        if (zv >= 0)
        begin
            d_next.x = xv - ys;
            d_next.y = yv + xs;
            d_next.z = zv - at;
        end
        else
        begin
            d_next.x = xv + ys;
            d_next.y = yv - xs;
            d_next.z = zv + at;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

// ===== rtl/gcrb_vec_cell.sv =====
// One vectoring-mode CORDIC iteration with its output register.
// Depends on gcrb_pkg for the data word and the arctangent table.
module gcrb_vec_cell (
    input  logic                          clk,
    input  logic                          en,
    input  logic [gcrb_pkg::STEP_W-1:0]   step,
    input  gcrb_pkg::cordic_t             d_in,
    output gcrb_pkg::cordic_t             d_out
);

    gcrb_pkg::cordic_t d_next;
    gcrb_pkg::cordic_t d_reg;
    logic signed [gcrb_pkg::CORDIC_W-1:0] xv;
    logic signed [gcrb_pkg::CORDIC_W-1:0] yv;
    logic signed [gcrb_pkg::CORDIC_W-1:0] xs;
    logic signed [gcrb_pkg::CORDIC_W-1:0] ys;
    logic signed [gcrb_pkg::ZW-1:0]       zv;
    logic signed [gcrb_pkg::ZW-1:0]       at;

    always_comb
    begin
        xv = d_in.x;
        yv = d_in.y;
        zv = d_in.z;
        xs = xv >>> step;
        ys = yv >>> step;
        at = signed'(gcrb_pkg::ZW'(gcrb_pkg::atan_entry(step)));
        // drive y toward zero, accumulate the angle turned
        if (yv > 0)
        begin
            d_next.x = xv + ys;
            d_next.y = yv - xs;
            d_next.z = zv + at;
        end
        else
        begin
            d_next.x = xv - ys;
            d_next.y = yv + xs;
            d_next.z = zv - at;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

// ===== rtl/gcrb_sqrt_cell.sv =====
// One step of the bit-serial integer square root, one result bit per cell.
// Depends on gcrb_pkg for the radicand and root word.
module gcrb_sqrt_cell (
    input  logic                          clk,
    input  logic                          en,
    input  logic [gcrb_pkg::STEP_W-1:0]   step,
    input  gcrb_pkg::sqrt_t               d_in,
    output gcrb_pkg::sqrt_t               d_out
);

    gcrb_pkg::sqrt_t d_next;
    gcrb_pkg::sqrt_t d_reg;
    logic [5:0]                    sh;
    logic [gcrb_pkg::ROOT_W-1:0]   bitv;
    logic [gcrb_pkg::ROOT_W-1:0]   trial;

    always_comb
    begin
        sh    = 6'd62 - {step, 1'b0};
        bitv  = gcrb_pkg::ROOT_W'(1) << sh;
        trial = d_in.root + bitv;
        if (d_in.n >= trial)
        begin
            d_next.n    = d_in.n - trial;
            d_next.root = (d_in.root >> 1) + bitv;
        end
        else
        begin
            d_next.n    = d_in.n;
            d_next.root = d_in.root >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

// ===== rtl/great_circle_range_bearing.sv =====
// Top level of the great-circle range and bearing block.
// Depends on gcrb_pkg, gcrb_rot_cell, gcrb_vec_cell and gcrb_sqrt_cell.
//
// Usage:
//   Input channel (item_valid / item_stall) carries start and end latitude and
//   longitude, signed, degrees times 65536. Output channel (result_valid /
//   result_stall) returns range_out in 1/256 km and bearing_out in degrees times
//   65536, one result per request, in order.
//   Configuration channel (cfg_valid / cfg_ready, always ready) loads
//   sphere_radius_km; write it only while no request is in flight.
//   The pipeline has 2*CORDIC_STEPS + SQRT_STEPS + 13 register stages, set by
//   one of the four rotation rows, the 32 root cells and the vectoring cells
//   in series. One request is taken per cycle while item_stall is low.
//   Reset empties the pipeline and the output stage and sets the radius to 6371.
//   When the receiver stalls, the output register holds its result and one
//   more result lands in a skid register; the whole pipeline then freezes and
//   item_stall rises until the skid register drains.
module great_circle_range_bearing (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic signed [24:0] start_latitude,
    input  logic signed [24:0] start_longitude,
    input  logic signed [24:0] end_latitude,
    input  logic signed [24:0] end_longitude,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [22:0]        range_out,
    output logic [24:0]        bearing_out,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [12:0]        sphere_radius_km
);

    localparam int CS  = gcrb_pkg::CORDIC_STEPS;
    localparam int SQ  = gcrb_pkg::SQRT_STEPS;
    localparam int LAT = gcrb_pkg::PIPE_LAT;
    localparam int DD  = gcrb_pkg::DEG_DELAY;
    localparam int CW  = gcrb_pkg::CORDIC_W;
    localparam int MW  = gcrb_pkg::MW;
    localparam int SW  = gcrb_pkg::SW;
    localparam int RW  = gcrb_pkg::ROOT_W;

    typedef struct packed {
        logic neg;
        logic zero;
    } bside_t;

    logic            en;
    logic [LAT-1:0]  vld_reg;
    logic [12:0]     radius_reg;

    // ---------------- angle conversion ----------------
    logic signed [24:0] coord [4];
    logic [25:0] cv_v_reg  [4];
    logic [52:0] cv_p_reg  [4];
    logic [20:0] q1_reg    [4];
    logic [45:0] cv_p2_reg [4];
    logic [31:0] turns_reg [4];
    logic [31:0] ang       [4];

    assign coord[0] = start_latitude;
    assign coord[1] = end_latitude;
    assign coord[2] = start_longitude;
    assign coord[3] = end_longitude;

    assign ang[0] = turns_reg[0];
    assign ang[1] = turns_reg[1];
    assign ang[2] = turns_reg[1] - turns_reg[0];
    assign ang[3] = turns_reg[3] - turns_reg[2];

    // ---------------- rotation rows ----------------
    gcrb_pkg::cordic_t rot_in_reg [4];
    gcrb_pkg::cordic_t rot_chain  [4][CS+1];
    logic [3:0]        flip_dly_reg [CS+1];
    logic [3:0]        flip_now;
    logic signed [SW-1:0] sin_reg [4];
    logic signed [SW-1:0] cos_reg [4];

    for (genvar l = 0; l < 4; l++)
    begin : g_conv
        logic signed [26:0] vs;
        logic [25:0]        vp;
        logic [20:0]        q1;
        logic [25:0]        r1w;
        logic [18:0]        tq;
        logic [31:0]        sum_a;
        logic [31:0]        bang;

        assign vs    = 27'(coord[l]) + signed'(gcrb_pkg::LAT_BIAS);
        assign vp    = vs[25:0];
        assign q1    = cv_p_reg[l][52:32];
        assign r1w   = cv_v_reg[l] - (26'(q1) * 26'd45);
        assign tq    = {r1w[5:0], 13'b0} + 19'd22;
        assign sum_a = ang[l] + 32'h4000_0000;
        assign flip_now[l] = sum_a[31];
        assign bang  = sum_a[31] ? (ang[l] + 32'h8000_0000) : ang[l];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cv_v_reg[l]  <= vp;
                cv_p_reg[l]  <= 53'(vp) * 53'(gcrb_pkg::DIV45_M);
                q1_reg[l]    <= q1;
                cv_p2_reg[l] <= 46'(tq) * 46'(gcrb_pkg::DIV45_M);
                turns_reg[l] <= 32'({q1_reg[l], 13'b0}) + 32'(cv_p2_reg[l][45:32]);
                rot_in_reg[l].x <= gcrb_pkg::CORDIC_K;
                rot_in_reg[l].y <= '0;
                rot_in_reg[l].z <= gcrb_pkg::ZW'(signed'(bang));
            end
        end

        assign rot_chain[l][0] = rot_in_reg[l];

        for (genvar i = 0; i < CS; i++)
        begin : g_rot
            gcrb_rot_cell u_cell (
                .clk   (clk),
                .en    (en),
                .step  (gcrb_pkg::STEP_W'(i)),
                .d_in  (rot_chain[l][i]),
                .d_out (rot_chain[l][i+1])
            );
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sin_reg[l] <= SW'(flip_dly_reg[CS][l] ? -rot_chain[l][CS].y
                                                      : rot_chain[l][CS].y);
                cos_reg[l] <= SW'(flip_dly_reg[CS][l] ? -rot_chain[l][CS].x
                                                      : rot_chain[l][CS].x);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flip_dly_reg[0] <= flip_now;
        end
    end

    for (genvar i = 1; i <= CS; i++)
    begin : g_flip
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                flip_dly_reg[i] <= flip_dly_reg[i-1];
            end
        end
    end

    // ---------------- haversine term and bearing vector ----------------
    logic signed [MW-1:0] sl1, cl1, sl2, cl2, cdla, cdlo, sdlo;
    logic signed [MW-1:0] hla_reg, m1_reg, by1_reg, t1_reg, m2_reg, sl1_reg, cl2_reg;
    logic signed [MW-1:0] a_reg, t2_reg, by2_reg, t1b_reg;
    logic [RW-1:0]        na_reg, nb_reg;
    logic signed [MW:0]   bx_reg;
    logic signed [MW-1:0] by3_reg;
    logic [30:0]          a_cl;
    logic signed [CW-1:0] bxw, byw;

    assign sl1  = MW'(sin_reg[0]);
    assign cl1  = MW'(cos_reg[0]);
    assign sl2  = MW'(sin_reg[1]);
    assign cl2  = MW'(cos_reg[1]);
    assign cdla = MW'(cos_reg[2]);
    assign sdlo = MW'(sin_reg[3]);
    assign cdlo = MW'(cos_reg[3]);

    always_comb
    begin
        if (a_reg < 0)
        begin
            a_cl = '0;
        end
        else if (a_reg > gcrb_pkg::ONE_Q30)
        begin
            a_cl = 31'(gcrb_pkg::ONE_Q30);
        end
        else
        begin
            a_cl = a_reg[30:0];
        end
    end

    assign bxw = CW'(bx_reg);
    assign byw = CW'(by3_reg);

    gcrb_pkg::sqrt_t   sq_chain [2][SQ+1];
    gcrb_pkg::cordic_t bv_chain [CS+1];
    gcrb_pkg::cordic_t dv_chain [CS+1];
    gcrb_pkg::sqrt_t   sq_in_reg [2];
    gcrb_pkg::cordic_t bv_in_reg;
    bside_t            bs_dly_reg [CS+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hla_reg <= (gcrb_pkg::ONE_Q30 - cdla) >>> 1;
            m1_reg  <= gcrb_pkg::mulq((gcrb_pkg::ONE_Q30 - cdlo) >>> 1, cl1);
            by1_reg <= gcrb_pkg::mulq(sdlo, cl2);
            t1_reg  <= gcrb_pkg::mulq(cl1, sl2);
            m2_reg  <= gcrb_pkg::mulq(cl2, cdlo);
            sl1_reg <= sl1;
            cl2_reg <= cl2;

            a_reg   <= hla_reg + gcrb_pkg::mulq(m1_reg, cl2_reg);
            t2_reg  <= gcrb_pkg::mulq(sl1_reg, m2_reg);
            by2_reg <= by1_reg;
            t1b_reg <= t1_reg;

            na_reg  <= {2'b0, a_cl, 30'b0};
            nb_reg  <= {2'b0, 31'(gcrb_pkg::ONE_Q30) - a_cl, 30'b0};
            bx_reg  <= (MW+1)'(t1b_reg) - (MW+1)'(t2_reg);
            by3_reg <= by2_reg;

            // both root lanes and the bearing vector start here
            sq_in_reg[0].n    <= na_reg;
            sq_in_reg[0].root <= '0;
            sq_in_reg[1].n    <= nb_reg;
            sq_in_reg[1].root <= '0;
            bv_in_reg.x       <= (bx_reg < 0) ? -bxw : bxw;
            bv_in_reg.y       <= (bx_reg < 0) ? -byw : byw;
            bv_in_reg.z       <= '0;
            bs_dly_reg[0].neg  <= (bx_reg < 0);
            bs_dly_reg[0].zero <= (bx_reg == 0) && (by3_reg == 0);
        end
    end

    for (genvar i = 1; i <= CS; i++)
    begin : g_bside
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                bs_dly_reg[i] <= bs_dly_reg[i-1];
            end
        end
    end

    // ---------------- root rows ----------------
    for (genvar l = 0; l < 2; l++)
    begin : g_sqrt_lane
        assign sq_chain[l][0] = sq_in_reg[l];
        for (genvar i = 0; i < SQ; i++)
        begin : g_sqrt
            gcrb_sqrt_cell u_cell (
                .clk   (clk),
                .en    (en),
                .step  (gcrb_pkg::STEP_W'(i)),
                .d_in  (sq_chain[l][i]),
                .d_out (sq_chain[l][i+1])
            );
        end
    end

    // ---------------- vectoring rows ----------------
    assign bv_chain[0]   = bv_in_reg;
    assign dv_chain[0].x = CW'(sq_chain[1][SQ].root);
    assign dv_chain[0].y = CW'(sq_chain[0][SQ].root);
    assign dv_chain[0].z = '0;

    for (genvar i = 0; i < CS; i++)
    begin : g_vec
        gcrb_vec_cell u_bcell (
            .clk   (clk),
            .en    (en),
            .step  (gcrb_pkg::STEP_W'(i)),
            .d_in  (bv_chain[i]),
            .d_out (bv_chain[i+1])
        );
        gcrb_vec_cell u_dcell (
            .clk   (clk),
            .en    (en),
            .step  (gcrb_pkg::STEP_W'(i)),
            .d_in  (dv_chain[i]),
            .d_out (dv_chain[i+1])
        );
    end

    // ---------------- range scaling ----------------
    logic signed [gcrb_pkg::ZW-1:0] dz;
    logic [30:0] z_cl;
    logic [47:0] ph_reg, pl_reg;
    logic [63:0] rq_sum;
    logic [39:0] rq_reg;
    logic [32:0] rh_reg, rl_reg;
    logic [52:0] rng_sum;
    logic [22:0] rng_reg;

    assign dz = dv_chain[CS].z;

    always_comb
    begin
        if (dz < 0)
        begin
            z_cl = '0;
        end
        else if (dz > gcrb_pkg::ZW'(gcrb_pkg::ONE_Q30))
        begin
            z_cl = 31'(gcrb_pkg::ONE_Q30);
        end
        else
        begin
            z_cl = dz[30:0];
        end
    end

    assign rq_sum  = (64'(ph_reg) << gcrb_pkg::RC_SPLIT) + 64'(pl_reg) + (64'd1 << 23);
    assign rng_sum = (53'(rh_reg) << 20) + 53'(rl_reg) + (53'd1 << 29);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ph_reg  <= 48'(z_cl) * 48'(gcrb_pkg::RC_HI);
            pl_reg  <= 48'(z_cl) * 48'(gcrb_pkg::RC_LO);
            rq_reg  <= rq_sum[63:24];
            rh_reg  <= 33'(radius_reg) * 33'(rq_reg[39:20]);
            rl_reg  <= 33'(radius_reg) * 33'(rq_reg[19:0]);
            rng_reg <= rng_sum[52:30];
        end
    end

    // ---------------- bearing scaling ----------------
    logic [31:0] bt;
    logic [40:0] bprod_reg;
    logic [40:0] dsum;
    logic [24:0] deg_raw;
    logic [24:0] deg_dly_reg [DD+1];

    assign bt = bs_dly_reg[CS].zero ? 32'd0
              : ({bs_dly_reg[CS].neg, 31'b0} + bv_chain[CS].z[31:0]);
    assign dsum    = bprod_reg + 41'd32768;
    assign deg_raw = dsum[40:16];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bprod_reg      <= 41'(bt) * 41'd360;
            deg_dly_reg[0] <= (deg_raw >= gcrb_pkg::FULL_DEG) ? deg_raw - gcrb_pkg::FULL_DEG
                                                              : deg_raw;
        end
    end

    // align bearing with the longer range path
    for (genvar i = 1; i <= DD; i++)
    begin : g_deg
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                deg_dly_reg[i] <= deg_dly_reg[i-1];
            end
        end
    end

    // ---------------- control, output stage, configuration ----------------
    logic        result_valid_reg;
    logic        skid_valid_reg;
    logic [22:0] range_reg, skid_range_reg;
    logic [24:0] bearing_reg, skid_bearing_reg;
    logic        take;
    logic        push;

    assign en   = !skid_valid_reg;
    assign take = result_valid_reg && !result_stall;
    assign push = en && vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg          <= '0;
            radius_reg       <= 13'd6371;
            result_valid_reg <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                vld_reg <= {vld_reg[LAT-2:0], item_valid};
            end
            if (cfg_valid && cfg_ready)
            begin
                radius_reg <= sphere_radius_km;
            end
            if (push)
            begin
                if (!result_valid_reg || take)
                begin
                    result_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (take)
            begin
                if (skid_valid_reg)
                begin
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    result_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (push && (!result_valid_reg || take))
        begin
            range_reg   <= rng_reg;
            bearing_reg <= deg_dly_reg[DD];
        end
        else if (push)
        begin
            skid_range_reg   <= rng_reg;
            skid_bearing_reg <= deg_dly_reg[DD];
        end
        else if (take && skid_valid_reg)
        begin
            range_reg   <= skid_range_reg;
            bearing_reg <= skid_bearing_reg;
        end
    end

    assign item_stall   = skid_valid_reg;
    assign result_valid = result_valid_reg;
    assign range_out    = range_reg;
    assign bearing_out  = bearing_reg;
    assign cfg_ready    = 1'b1;

    // ---------------- assertions ----------------
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> result_valid_reg)
        else $error("skid register full while output register empty");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (push && result_valid_reg && !take) |-> !skid_valid_reg)
        else $error("result pushed into a full skid register");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |=> (vld_reg == $past(vld_reg)))
        else $error("pipeline moved while frozen");

    a_bearing_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (bearing_reg < gcrb_pkg::FULL_DEG))
        else $error("bearing not folded below a full circle");

endmodule

// ===== bench/great_circle_range_bearing_checker.sv =====
// Checker for great_circle_range_bearing: watches the request, result and radius channels.
// Predicts range and bearing with its own fixed-point CORDIC model and compares in order.
// Depends on gcrb_pkg for the CORDIC step count.
`timescale 1ns / 1ps

module great_circle_range_bearing_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_stall,
    input  logic [24:0] start_latitude,
    input  logic [24:0] start_longitude,
    input  logic [24:0] end_latitude,
    input  logic [24:0] end_longitude,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic [22:0] range_out,
    input  logic [24:0] bearing_out,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [12:0] sphere_radius_km,
    output int          failures,
    output int          outstanding
);

    typedef struct {
        logic [22:0] range_km256;
        logic [24:0] bearing_deg;
    } fix_t;

    localparam int ROT_STEPS = (gcrb_pkg::CORDIC_STEPS > 32) ? 32 : gcrb_pkg::CORDIC_STEPS;
    localparam longint ONE_Q30 = 64'sd1 << 30;
    localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
    localparam logic [63:0] FULL_CIRCLE_DEG = 64'd23592960;

    longint arc_step [32];
    longint rot_start;
    logic [12:0] radius_km;
    fix_t pending_fixes [$];

    function automatic logic [63:0] int_root(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] b;
        root = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= root + b)
            begin
                n = n - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic longint q30_mul(input longint a, input longint b);
        return (a * b) >>> 30;
    endfunction

    function automatic logic [31:0] deg_to_turns(input logic [24:0] field);
        longint v;
        longint t;
        v = longint'($signed(field));
        t = v * 131072 + 360 + 720 * (64'sd1 << 42);
        return 32'(t / 720 - (64'sd1 << 42));
    endfunction

    task automatic sin_cos(input logic [31:0] a, output longint s, output longint c);
        logic flip;
        logic [31:0] b;
        longint z;
        longint x;
        longint y;
        longint nx;
        flip = ((a + 32'h40000000) & 32'h80000000) != 0;
        b = flip ? a + 32'h80000000 : a;
        z = longint'($signed(b));
        x = rot_start;
        y = 0;
        for (int i = 0; i < ROT_STEPS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i); y = y + (x >>> i); z = z - arc_step[i];
            end
            else
            begin
                nx = x + (y >>> i); y = y - (x >>> i); z = z + arc_step[i];
            end
            x = nx;
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endtask

    function automatic longint angle_of(input longint y, input longint x);
        longint z;
        longint nx;
        z = 0;
        for (int i = 0; i < ROT_STEPS; i++)
        begin
            if (y > 0)
            begin
                nx = x + (y >>> i); y = y - (x >>> i); z = z + arc_step[i];
            end
            else
            begin
                nx = x - (y >>> i); y = y + (x >>> i); z = z - arc_step[i];
            end
            x = nx;
        end
        return z;
    endfunction

    task automatic predict_fix(input logic [24:0] lat1_f, input logic [24:0] lon1_f,
                               input logic [24:0] lat2_f, input logic [24:0] lon2_f,
                               output fix_t fix);
        logic [31:0] lat1, lon1, lat2, lon2, bt;
        longint sl1, cl1, sl2, cl2, sdla, cdla, sdlo, cdlo;
        longint hav, half_c, by, bx;
        logic [63:0] sa, sb, rad_q38, range_q8, deg, base;
        lat1 = deg_to_turns(lat1_f);
        lon1 = deg_to_turns(lon1_f);
        lat2 = deg_to_turns(lat2_f);
        lon2 = deg_to_turns(lon2_f);
        sin_cos(lat1, sl1, cl1);
        sin_cos(lat2, sl2, cl2);
        sin_cos(lat2 - lat1, sdla, cdla);
        sin_cos(lon2 - lon1, sdlo, cdlo);

        hav = ((ONE_Q30 - cdla) >>> 1) + q30_mul(q30_mul((ONE_Q30 - cdlo) >>> 1, cl1), cl2);
        if (hav < 0) hav = 0;
        if (hav > ONE_Q30) hav = ONE_Q30;
        sa = int_root(64'(hav) << 30);
        sb = int_root(64'(ONE_Q30 - hav) << 30);
        half_c = angle_of(longint'(sa), longint'(sb));
        if (half_c < 0) half_c = 0;
        if (half_c > ONE_Q30) half_c = ONE_Q30;
        rad_q38 = (64'(2 * half_c) * TWO_PI_Q30 + (64'd1 << 23)) >> 24;
        range_q8 = (64'(radius_km) * rad_q38 + (64'd1 << 29)) >> 30;

        by = q30_mul(sdlo, cl2);
        bx = q30_mul(cl1, sl2) - q30_mul(sl1, q30_mul(cl2, cdlo));
        if (bx == 0 && by == 0)
            bt = 0;
        else
        begin
            base = 0;
            // mirror into the right half plane, add half a turn back
            if (bx < 0)
            begin
                bx = -bx; by = -by; base = 64'h80000000;
            end
            bt = 32'(base + 64'(angle_of(by, bx)));
        end
        deg = (64'(bt) * 360 + 32768) >> 16;
        if (deg >= FULL_CIRCLE_DEG) deg = deg - FULL_CIRCLE_DEG;
        fix.range_km256 = range_q8[22:0];
        fix.bearing_deg = deg[24:0];
    endtask

    task automatic report_mismatch(input string what, input longint want, input longint got);
        $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
        failures++;
    endtask

    initial
    begin
        logic [63:0] rem, q, g2, g;
        longint r, term;
        int e;
        failures = 0;
        outstanding = 0;
        radius_km = 13'd6371;
        arc_step[0] = 64'sd1 << 29;
        for (int i = 1; i < 32; i++)
        begin
            r = 0;
            // arctangent series in Q60, then divide by two pi for turns
            for (int k = 0; ; k++)
            begin
                e = 60 - i * (2 * k + 1);
                if (e < 0) break;
                term = longint'((64'd1 << e) / 64'(2 * k + 1));
                r = (k & 1) ? r - term : r + term;
            end
            rem = 64'(r);
            q = 0;
            for (int k = 0; k < 33; k++)
            begin
                rem = rem << 1;
                q = q << 1;
                if (rem >= TWO_PI_Q60)
                begin
                    rem = rem - TWO_PI_Q60;
                    q = q | 1;
                end
            end
            arc_step[i] = longint'((q + 1) >> 1);
        end
        g2 = 64'd1 << 60;
        for (int i = 0; i < ROT_STEPS; i++) g2 = g2 + (g2 >> (2 * i));
        g = int_root(g2);
        rot_start = longint'(((64'd1 << 60) + (g >> 1)) / g);
    end

    always @(posedge clk)
    begin
        fix_t want;
        fix_t got;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                radius_km = sphere_radius_km;
            if (result_valid && !result_stall)
            begin
                if (pending_fixes.size() == 0)
                begin
                    $display("%0t result with no request waiting: range %0d bearing %0d",
                             $realtime, range_out, bearing_out);
                    failures++;
                end
                else
                begin
                    want = pending_fixes.pop_front();
                    if (range_out !== want.range_km256)
                        report_mismatch("range_out", longint'(want.range_km256),
                                        longint'(range_out));
                    if (bearing_out !== want.bearing_deg)
                        report_mismatch("bearing_out", longint'(want.bearing_deg),
                                        longint'(bearing_out));
                end
            end
            if (item_valid && !item_stall)
            begin
                predict_fix(start_latitude, start_longitude, end_latitude, end_longitude, got);
                pending_fixes.push_back(got);
            end
            outstanding = pending_fixes.size();
        end
    end

endmodule

// ===== bench/great_circle_range_bearing_test.sv =====
// Top of the great_circle_range_bearing bench: clock, reset, request and radius stimulus.
// Instantiates the block and great_circle_range_bearing_checker; gives the verdict.
// Depends on gcrb_pkg through the block and the checker.
`timescale 1ns / 1ps

module great_circle_range_bearing_test;

    localparam int DEG = 65536;
    localparam int FIELD_MAX = 11796480;
    localparam int IDLE_LIMIT = 6000;
    localparam int LONG_HOLD = 400;

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_stall;
    logic signed [24:0] start_latitude;
    logic signed [24:0] start_longitude;
    logic signed [24:0] end_latitude;
    logic signed [24:0] end_longitude;
    logic               result_valid;
    logic               result_stall;
    logic [22:0]        range_out;
    logic [24:0]        bearing_out;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [12:0]        sphere_radius_km;

    int failures;
    int outstanding;
    int gap_pct;
    int stall_pct;
    int hold_requests;
    int hold_served;
    int hold_left;
    int quiet_cycles;

    great_circle_range_bearing i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .item_stall       (item_stall),
        .start_latitude   (start_latitude),
        .start_longitude  (start_longitude),
        .end_latitude     (end_latitude),
        .end_longitude    (end_longitude),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .range_out        (range_out),
        .bearing_out      (bearing_out),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .sphere_radius_km (sphere_radius_km)
    );

    great_circle_range_bearing_checker i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .item_stall       (item_stall),
        .start_latitude   (start_latitude),
        .start_longitude  (start_longitude),
        .end_latitude     (end_latitude),
        .end_longitude    (end_longitude),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .range_out        (range_out),
        .bearing_out      (bearing_out),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .sphere_radius_km (sphere_radius_km),
        .failures         (failures),
        .outstanding      (outstanding)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // receiver: random stall, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            result_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served <= hold_requests;
            hold_left <= LONG_HOLD - 1;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready) || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("great_circle_range_bearing verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [24:0] pick_coord(input int span);
        return 25'($signed($urandom_range(2 * span)) - span);
    endfunction

    task automatic send_request(input logic [24:0] lat1, input logic [24:0] lon1,
                                input logic [24:0] lat2, input logic [24:0] lon2);
        int gap;
        gap = 0;
        if ($urandom_range(99) < gap_pct) gap = $urandom_range(4, 1);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start_latitude  <= lat1;
        start_longitude <= lon1;
        end_latitude    <= lat2;
        end_longitude   <= lon2;
        item_valid      <= 1'b1;
        @(posedge clk);
        while (item_stall) @(posedge clk);
    endtask

    task automatic drain_pipeline();
        item_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic load_radius(input logic [12:0] km);
        drain_pipeline();
        repeat (100) @(posedge clk);
        sphere_radius_km <= km;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random(input int count);
        int kind;
        logic [24:0] lat1, lon1, lat2, lon2;
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(99);
            lat1 = pick_coord(90 * DEG);
            lon1 = pick_coord(180 * DEG);
            lat2 = pick_coord(90 * DEG);
            lon2 = pick_coord(180 * DEG);
            if (kind < 15)
            begin
                // any 25-bit pattern, wrapping angles included
                lat1 = 25'($urandom); lon1 = 25'($urandom);
                lat2 = 25'($urandom); lon2 = 25'($urandom);
            end
            else if (kind < 25)
            begin
                lat1 = pick_coord(FIELD_MAX); lon1 = pick_coord(FIELD_MAX);
                lat2 = pick_coord(FIELD_MAX); lon2 = pick_coord(FIELD_MAX);
            end
            else if (kind < 40)
            begin
                // short hops and coincident points
                lat2 = lat1 + pick_coord($urandom_range(2) == 0 ? 0 : 4096);
                lon2 = lon1 + pick_coord($urandom_range(2) == 0 ? 0 : 4096);
            end
            else if (kind < 48)
            begin
                // near antipodes
                lat2 = -lat1 + pick_coord(64);
                lon2 = lon1 + 25'(180 * DEG) + pick_coord(64);
            end
            send_request(lat1, lon1, lat2, lon2);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        start_latitude = '0;
        start_longitude = '0;
        end_latitude = '0;
        end_longitude = '0;
        cfg_valid = 1'b0;
        sphere_radius_km = 13'd6371;
        result_stall = 1'b0;
        gap_pct = 0;
        stall_pct = 0;
        hold_requests = 0;
        hold_served = 0;
        hold_left = 0;
        quiet_cycles = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed points at the default radius
        send_request(25'd0, 25'd0, 25'd0, 25'd0);
        send_request(25'(FIELD_MAX), 25'(FIELD_MAX), 25'(FIELD_MAX), 25'(FIELD_MAX));
        send_request(25'(-FIELD_MAX), 25'(-FIELD_MAX), 25'(FIELD_MAX), 25'(FIELD_MAX));
        send_request(25'h0FFFFFF, 25'h1000000, 25'h1000000, 25'h0FFFFFF);
        send_request(25'(90 * DEG), 25'd0, 25'(-90 * DEG), 25'd0);
        send_request(25'(90 * DEG), 25'(17 * DEG), 25'(90 * DEG), 25'(-123 * DEG));
        send_request(25'd0, 25'd0, 25'd0, 25'(180 * DEG));
        send_request(25'd0, 25'(-180 * DEG), 25'd0, 25'(180 * DEG));
        send_request(25'd0, 25'd0, 25'(DEG), 25'd0);
        send_request(25'd0, 25'd0, 25'd0, 25'(DEG));
        send_request(25'd0, 25'd0, 25'(-DEG), 25'd0);
        send_request(25'd0, 25'd0, 25'd0, 25'(-DEG));
        send_request(25'(45 * DEG), 25'(45 * DEG), 25'(-45 * DEG), 25'(-135 * DEG));
        send_request(25'(51 * DEG), 25'd0, 25'(40 * DEG), 25'(-74 * DEG));
        send_request(25'(-33 * DEG), 25'(151 * DEG), 25'(35 * DEG), 25'(139 * DEG));
        send_request(25'd1, 25'd1, 25'd1, 25'd2);
        send_request(25'(-1), 25'(-1), 25'(-1), 25'(-1));
        send_request(25'd0, 25'd0, 25'd1, 25'd0);
        send_request(25'(-90 * DEG), 25'd0, 25'(-90 * DEG), 25'(90 * DEG));

        load_radius(13'd8191);
        send_random(300);

        load_radius(13'd1);
        gap_pct = 47;
        send_random(300);

        load_radius(13'($urandom_range(8191, 1)));
        gap_pct = 0;
        stall_pct = 47;
        hold_requests <= hold_requests + 1;
        send_random(300);

        load_radius(13'd0);
        gap_pct = 31;
        stall_pct = 31;
        send_random(100);

        load_radius(13'd6371);
        send_random(500);
        // pause until every result is back, then run flat out
        drain_pipeline();
        gap_pct = 0;
        stall_pct = 0;
        send_random(330);

        drain_pipeline();
        repeat (120) @(posedge clk);
        if (failures == 0)
            $display("great_circle_range_bearing verification clean");
        else
            $display("great_circle_range_bearing verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/gcrb_pkg.sv
rtl/gcrb_rot_cell.sv
rtl/gcrb_vec_cell.sv
rtl/gcrb_sqrt_cell.sv
rtl/great_circle_range_bearing.sv
bench/great_circle_range_bearing_checker.sv
bench/great_circle_range_bearing_test.sv
